>>> hdl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, defaults and request codes of the interpolation table core.
// ----------------------------------------------------------------------------
package pli_pkg;

  // default table size and fraction width
  localparam int DepthDef    = 256;
  localparam int FracBitsDef = 16;

  // fixed field widths
  localparam int DataW  = 32;
  localparam int IndexW = 8;
  localparam int CountW = 9;
  localparam int SegW   = 8;

  // request kinds
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

endpackage

>>> hdl/piecewise_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Sample table with binary search, serial divider and clamped interpolation.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o): a load request (mode_i = 0)
//   writes time and value of slot entry_index_i and gives no result; the
//   sequencer stays idle. a query request (mode_i = 1) gives one result.
//   output channel (out_valid_o / out_ready_i): result_value_o, segment_o,
//   clamped_o, held in an output register until taken.
//   cfg_we_i / cfg_wdata_i set num_samples (entries in use); write it only
//   while no query is in flight.
// sequence
//   a query is first compared with the first point, then with the last
//   point, and gives a clamped result at or before the first or at or
//   beyond the last. an interpolated query runs a binary search, one table
//   read per search step through the single table read port, then one
//   quotient bit per cycle of the shared restoring divider, then one
//   multiply and one add step. in_ready_o is high only while the sequencer
//   is idle.
// reset
//   num_samples returns to 1, the sequencer to idle, no result pending.
//   table contents are not cleared: load entries before querying them.
// stall
//   a finished result waits in the output register; the next request is
//   taken meanwhile and its own result waits in the sequencer until the
//   output register is free.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_core #(
  parameter int DEPTH     = pli_pkg::DepthDef,
  parameter int FRAC_BITS = pli_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [pli_pkg::CountW-1:0]  cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [pli_pkg::IndexW-1:0]  entry_index_i,
  input  logic signed [pli_pkg::DataW-1:0] sample_time_i,
  input  logic signed [pli_pkg::DataW-1:0] sample_value_i,
  input  logic signed [pli_pkg::DataW-1:0] query_time_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [pli_pkg::DataW-1:0] result_value_o,
  output logic [pli_pkg::SegW-1:0]    segment_o,
  output logic                        clamped_o
);

  import pli_pkg::*;

  localparam int AW   = $clog2(DEPTH);          // table address width
  localparam int QW   = FRAC_BITS + 1;          // fraction incl. the value one
  localparam int CntW = $clog2(FRAC_BITS);      // divider step counter
  localparam int PW   = QW + 1 + DataW + 1;     // product width
  localparam int DW   = DataW + 1;              // differences
  localparam int RW   = DataW + 2;              // divider remainder

  // one-hot sequencer
  typedef enum logic [11:0] {
    StIdle    = 12'h001,
    StFirst   = 12'h002,
    StLast    = 12'h004,
    StSel     = 12'h008,
    StSrch    = 12'h010,
    StFetchLo = 12'h020,
    StFetchHi = 12'h040,
    StCheck   = 12'h080,
    StDiv     = 12'h100,
    StMul     = 12'h200,
    StAdd     = 12'h400,
    StDone    = 12'h800
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [CountW-1:0] num_samples_q;

  // datapath registers
  logic signed [DataW-1:0] t_q, t_d;
  logic [AW-1:0]           last_q, last_d;
  logic [AW-1:0]           lo_q, lo_d;
  logic [AW-1:0]           hi_q, hi_d;
  logic signed [DataW-1:0] t0_q, t0_d;
  logic signed [DataW-1:0] v0_q, v0_d;
  logic signed [DW-1:0]    num_q, num_d;
  logic signed [DW-1:0]    den_q, den_d;
  logic signed [DW-1:0]    diff_q, diff_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic signed [PW-1:0]    prod_q, prod_d;
  logic signed [DataW-1:0] res_q, res_d;
  logic [SegW-1:0]         seg_q, seg_d;
  logic                    clamp_q, clamp_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_value_q, out_value_d;
  logic [SegW-1:0]         out_seg_q, out_seg_d;
  logic                    out_clamp_q, out_clamp_d;

  // table ports
  logic                    tbl_we;
  logic [AW-1:0]           tbl_waddr;
  logic [AW-1:0]           tbl_raddr;
  logic signed [DataW-1:0] time_rd;
  logic signed [DataW-1:0] value_rd;

  // helpers
  logic                    in_accept;
  logic                    load_ok;
  logic [AW-1:0]           last_n;
  logic [AW-1:0]           mid;
  logic [RW-1:0]           rem_sh;
  logic [RW-1:0]           den_ext;
  logic signed [PW-1:0]    prod_sh;
  logic signed [PW-1:0]    sum;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;
  assign load_ok    = (32'(entry_index_i) < 32'(DEPTH));
  assign tbl_we     = in_accept && (mode_i == ModeLoad) && load_ok;
  assign tbl_waddr  = AW'(entry_index_i);

  // index of the last entry in use, count clamped to 1..DEPTH
  always_comb begin
    if (num_samples_q == '0) begin
      last_n = '0;
    end else if (32'(num_samples_q) > 32'(DEPTH)) begin
      last_n = AW'(DEPTH - 1);
    end else begin
      last_n = AW'(num_samples_q - CountW'(1));
    end
  end

  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign rem_sh  = {rem_q[RW-2:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign sum     = prod_sh + {{(PW-DataW){v0_q[DataW-1]}}, v0_q};

  pli_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(sample_time_i),
    .raddr_i(tbl_raddr),
    .rdata_o(time_rd)
  );

  pli_ram #(
    .WIDTH(DataW),
    .DEPTH(DEPTH)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(sample_value_i),
    .raddr_i(tbl_raddr),
    .rdata_o(value_rd)
  );

  // sequencer and shared datapath
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    t0_d        = t0_q;
    v0_d        = v0_q;
    num_d       = num_q;
    den_d       = den_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    prod_d      = prod_q;
    res_d       = res_q;
    seg_d       = seg_q;
    clamp_d     = clamp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_seg_d   = out_seg_q;
    out_clamp_d = out_clamp_q;
    tbl_raddr   = '0;

    unique case (state_q)
      StIdle: begin
        // read of entry 0 is issued here for a query
        if (in_accept && (mode_i == ModeQuery)) begin
          t_d     = query_time_i;
          last_d  = last_n;
          state_d = StFirst;
        end
      end
      StFirst: begin
        if (t_q <= time_rd) begin
          res_d   = value_rd;
          seg_d   = '0;
          clamp_d = 1'b1;
          state_d = StDone;
        end else begin
          tbl_raddr = last_q;
          state_d   = StLast;
        end
      end
      StLast: begin
        if (t_q >= time_rd) begin
          res_d   = value_rd;
          seg_d   = '0;
          clamp_d = 1'b1;
          state_d = StDone;
        end else begin
          lo_d    = AW'(1);
          hi_d    = last_q;
          state_d = StSel;
        end
      end
      StSel: begin
        if (lo_q < hi_q) begin
          tbl_raddr = mid;
          state_d   = StSrch;
        end else begin
          tbl_raddr = lo_q - AW'(1);
          state_d   = StFetchLo;
        end
      end
      StSrch: begin
        // search for the first time above the query
        if (time_rd > t_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + AW'(1);
        end
        state_d = StSel;
      end
      StFetchLo: begin
        t0_d      = time_rd;
        v0_d      = value_rd;
        tbl_raddr = lo_q;
        state_d   = StFetchHi;
      end
      StFetchHi: begin
        num_d   = {t_q[DataW-1], t_q} - {t0_q[DataW-1], t0_q};
        den_d   = {time_rd[DataW-1], time_rd} - {t0_q[DataW-1], t0_q};
        diff_d  = {value_rd[DataW-1], value_rd} - {v0_q[DataW-1], v0_q};
        state_d = StCheck;
      end
      StCheck: begin
        if ((den_q <= 0) || (num_q < 0)) begin
          quo_d   = '0;
          state_d = StMul;
        end else if (num_q >= den_q) begin
          // fraction saturates at one
          quo_d   = QW'(1) << FRAC_BITS;
          state_d = StMul;
        end else begin
          rem_d   = {1'b0, num_q};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= den_ext) begin
          rem_d = rem_sh - den_ext;
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(FRAC_BITS - 1)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = $signed({1'b0, quo_q}) * diff_q;
        state_d = StAdd;
      end
      StAdd: begin
        // saturate to the signed 32-bit range
        if (sum[PW-1:DataW-1] == '0 || sum[PW-1:DataW-1] == '1) begin
          res_d = sum[DataW-1:0];
        end else if (sum[PW-1]) begin
          res_d = {1'b1, {(DataW-1){1'b0}}};
        end else begin
          res_d = {1'b0, {(DataW-1){1'b1}}};
        end
        seg_d   = SegW'(lo_q);
        clamp_d = 1'b0;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_seg_d   = seg_q;
          out_clamp_d = clamp_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      num_samples_q <= CountW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_samples_q <= cfg_wdata_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    last_q      <= last_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    t0_q        <= t0_d;
    v0_q        <= v0_d;
    num_q       <= num_d;
    den_q       <= den_d;
    diff_q      <= diff_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    cnt_q       <= cnt_d;
    prod_q      <= prod_d;
    res_q       <= res_d;
    seg_q       <= seg_d;
    clamp_q     <= clamp_d;
    out_value_q <= out_value_d;
    out_seg_q   <= out_seg_d;
    out_clamp_q <= out_clamp_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign segment_o      = out_seg_q;
  assign clamped_o      = out_clamp_q;

endmodule

>>> hdl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
